/* rtl/shd_pkg.sv */
// shared types and constants of the session handle table
`timescale 1ns / 1ps
`default_nettype none
package shd_pkg;

  typedef enum logic [2:0] {
    REQ_INIT, REQ_ALLOC, REQ_GET, REQ_FIND, REQ_UNREF, REQ_FREE, REQ_RX, REQ_AGE
  } req_t;

  typedef enum logic [1:0] {
    ST_OK, ST_NO_FREE, ST_NOT_FOUND, ST_BAD_REF
  } status_t;

  localparam logic [1:0] CFG_NUM_SESSIONS  = 2'd0;
  localparam logic [1:0] CFG_SRV_BASE      = 2'd1;
  localparam logic [1:0] CFG_AGEING_PERIOD = 2'd2;
  localparam logic [1:0] CFG_IDLE_LIMIT    = 2'd3;

  localparam logic [8:0]  RST_NUM_SESSIONS  = 9'd256;
  localparam logic [31:0] RST_SRV_BASE      = 32'd0;
  localparam logic [7:0]  RST_AGEING_PERIOD = 8'd10;
  localparam logic [15:0] RST_IDLE_LIMIT    = 16'd120;

  // remainder unit: bits retired per cycle and cycles per 32-bit word
  localparam int MOD_STEP_BITS = 4;
  localparam int MOD_CYCLES    = 32 / MOD_STEP_BITS;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_CLR, B_IDLE, B_AFIFO, B_ARD, B_RD, B_EXEC, B_AGE_RD, B_AGE_EX, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [7:0]  ageing_period;
    logic [15:0] idle_limit;
  } age_cfg_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] id;
    logic        released;
    logic [8:0]  released_count;
  } result_t;

endpackage
`default_nettype wire

/* rtl/shd_mod.sv */
// iterative remainder unit, 32-bit dividend by slot count
`timescale 1ns / 1ps
`default_nettype none
module shd_mod #(
  parameter int NUM_SLOTS = 256
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire [31:0]                        dividend,
  input  wire [$clog2(NUM_SLOTS+1)-1:0]     divisor,
  output logic                              done,
  output logic [$clog2(NUM_SLOTS)-1:0]      rem
);
  import shd_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int SW = $clog2(MOD_CYCLES);

  logic [31:0]   q_r, q_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] d_r;
  logic [SW-1:0] step_r;
  logic          busy_r, done_r;

  always_comb begin
    logic [CW:0] t;
    q_nxt = q_r;
    r_nxt = r_r;
    t     = '0;
    for (int k = 0; k < MOD_STEP_BITS; k++) begin
      t     = {r_nxt, q_nxt[31]};
      q_nxt = {q_nxt[30:0], 1'b0};
      if (t >= {1'b0, d_r}) t = t - {1'b0, d_r};
      r_nxt = t[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(MOD_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = IW'(r_r);

endmodule
`default_nettype wire

/* rtl/shd_front.sv */
// request intake: id derivation and slot index by remainder
`timescale 1ns / 1ps
`default_nettype none
module shd_front #(
  parameter int NUM_SLOTS = 256
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire [2:0]                                in_req_type,
  input  wire [31:0]                               in_session_id,
  input  wire [31:0]                               in_client_address,
  input  wire [7:0]                                in_cipher_kind,
  input  wire [31:0]                               srv_base,
  input  wire [$clog2(NUM_SLOTS+1)-1:0]            eff_n,
  input  wire                                      clearing,
  input  wire                                      q_full,
  output logic                                     push,
  output logic [3+32+8+$clog2(NUM_SLOTS)-1:0]      push_data
);
  import shd_pkg::*;

  localparam int IW   = $clog2(NUM_SLOTS);
  localparam int CW   = $clog2(NUM_SLOTS + 1);
  localparam int RstN = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;

  front_state_t  state_r, state_nxt;
  req_t          req_in, req_r;
  logic [31:0]   sid_in, sid_r;
  logic [7:0]    cph_r;
  logic [CW-1:0] active_n_r;
  logic          accept, need_idx, mod_done;
  logic [IW-1:0] mod_rem;

  assign req_in = req_t'(in_req_type);
  assign sid_in = (req_in == REQ_FIND) ? (in_client_address - srv_base - 32'd1)
                                       : in_session_id;
  assign accept = in_valid && in_ready;

  always_comb begin
    unique case (req_in) inside
      REQ_GET, REQ_FIND, REQ_UNREF, REQ_FREE, REQ_RX: need_idx = 1'b1;
      default:                                        need_idx = 1'b0;
    endcase
  end

  shd_mod #(.NUM_SLOTS(NUM_SLOTS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && need_idx),
    .dividend (sid_in),
    .divisor  (active_n_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = need_idx ? F_DIV : F_PUSH;
      F_DIV:   if (mod_done) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == F_IDLE) && !clearing;
    push      = (state_r == F_PUSH) && !q_full;
    push_data = {req_r, sid_r, cph_r, mod_rem};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      active_n_r <= CW'(RstN);
    end else begin
      state_r <= state_nxt;
      // later items are indexed with the slot count that init installs
      if (push && req_r == REQ_INIT) active_n_r <= eff_n;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_in;
      sid_r <= sid_in;
      cph_r <= in_cipher_kind;
    end
  end

endmodule
`default_nettype wire

/* rtl/shd_queue.sv */
// two-entry queue between intake and table engine
`timescale 1ns / 1ps
`default_nettype none
module shd_queue #(
  parameter int W = 51
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire [W-1:0]  push_data,
  input  wire          pop,
  output logic [W-1:0] head_data,
  output logic         full,
  output logic         empty
);
  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

/* rtl/shd_back.sv */
// table engine: slot records, free fifo, used list and result register
`timescale 1ns / 1ps
`default_nettype none
module shd_back #(
  parameter int NUM_SLOTS = 256,
  parameter int REF_BITS  = 17
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire [3+32+8+$clog2(NUM_SLOTS)-1:0]   q_data,
  input  wire                                  q_empty,
  output logic                                 q_pop,
  input  wire [$clog2(NUM_SLOTS+1)-1:0]        eff_n,
  input  shd_pkg::age_cfg_t                    age_cfg,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output shd_pkg::result_t                     out_res,
  output logic [REF_BITS-1:0]                  out_refs
);
  import shd_pkg::*;

  localparam int IW   = $clog2(NUM_SLOTS);
  localparam int CW   = $clog2(NUM_SLOTS + 1);
  localparam int RstN = (NUM_SLOTS < 256) ? NUM_SLOTS : 256;
  localparam logic [REF_BITS-1:0] RefMax = {1'b0, {(REF_BITS-1){1'b1}}};
  localparam logic [REF_BITS-1:0] RefOne = REF_BITS'(1);

  typedef struct packed {
    logic [31:0]         sid;
    logic [REF_BITS-1:0] refc;
    logic                flag;
    logic [15:0]         idle;
    logic [31:0]         rx;
    logic [31:0]         lrx;
  } rec_t;

  rec_t          rec_mem [NUM_SLOTS];
  logic [IW-1:0] fifo_mem [NUM_SLOTS];
  logic [IW-1:0] nxt_mem [NUM_SLOTS];
  logic [IW-1:0] prv_mem [NUM_SLOTS];
  logic [7:0]    cph_mem [NUM_SLOTS];

  rec_t          rec_q;
  logic [IW-1:0] fifo_q, nxt_q, prv_q;

  back_state_t   state_r, state_nxt;
  logic [IW-1:0] clr_cnt_r;
  logic          reply_r;
  logic [CW-1:0] active_n_r;
  logic [IW-1:0] free_head_r, used_head_r, used_tail_r;
  logic [CW-1:0] free_count_r, used_count_r, remain_r;
  logic [8:0]    relcnt_r;
  req_t          req_r;
  logic [31:0]   sid_r;
  logic [7:0]    cph_r;
  logic [IW-1:0] slot_r;
  logic          out_valid_r;
  result_t       res_r;
  logic [REF_BITS-1:0] refs_r;

  req_t          q_req;
  logic [2:0]    q_req_raw;
  logic [31:0]   q_sid;
  logic [7:0]    q_cph;
  logic [IW-1:0] q_idx;
  assign {q_req_raw, q_sid, q_cph, q_idx} = q_data;
  assign q_req = req_t'(q_req_raw);

  logic          out_free, clr_last, commit, emit, rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] fh_inc, push_addr;
  logic [CW:0]   push_sum;
  logic [32:0]   sid_sum;
  logic [31:0]   rel_sid;

  assign out_free = !out_valid_r || out_ready;
  assign clr_last = (clr_cnt_r == IW'(NUM_SLOTS - 1));
  assign clearing = (state_r == B_CLR) && !reply_r;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign commit   = ((state_r == B_EXEC) && out_free) || (state_r == B_AGE_EX);
  assign emit     = out_free && ((state_r == B_EXEC) || (state_r == B_DONE));
  assign rd_en    = (state_r == B_RD) || (state_r == B_ARD) ||
                    ((state_r == B_AGE_RD) && (remain_r != '0));
  assign rd_addr  = (state_r == B_ARD) ? fifo_q : slot_r;

  // free fifo pointer arithmetic, wrapping at the table depth
  assign fh_inc    = (free_head_r == IW'(NUM_SLOTS - 1)) ? '0 : free_head_r + 1'b1;
  assign push_sum  = (CW+1)'(free_head_r) + (CW+1)'(free_count_r);
  assign push_addr = (push_sum >= (CW+1)'(NUM_SLOTS)) ? IW'(push_sum - (CW+1)'(NUM_SLOTS))
                                                      : IW'(push_sum);

  // the next generation wraps to the slot index itself on overflow
  assign sid_sum = {1'b0, rec_q.sid} + 33'(active_n_r);
  assign rel_sid = sid_sum[32] ? 32'(slot_r) : sid_sum[31:0];

  // request decode against the record just read
  rec_t                nr;
  logic                wr, rel, app;
  status_t             st;
  logic [31:0]         idv;
  logic [REF_BITS-1:0] rf;
  logic                neg, is_zero, is_one, at_max, flg;
  logic [16:0]         t17;
  logic [15:0]         idl;

  always_comb begin
    neg     = rec_q.refc[REF_BITS-1];
    is_zero = (rec_q.refc == '0);
    is_one  = (rec_q.refc == RefOne);
    at_max  = (rec_q.refc == RefMax);
    nr  = rec_q;
    wr  = 1'b0;
    rel = 1'b0;
    app = 1'b0;
    st  = ST_OK;
    idv = '0;
    rf  = '0;
    flg = 1'b0;
    t17 = '0;
    idl = '0;
    if (state_r == B_EXEC) begin
      unique case (req_r) inside
        REQ_ALLOC: begin
          if (free_count_r == '0) begin
            st = ST_NO_FREE;
          end else begin
            nr.refc = RefOne;
            nr.flag = 1'b0;
            nr.idle = '0;
            nr.rx   = '0;
            nr.lrx  = '0;
            wr  = 1'b1;
            app = 1'b1;
            idv = rec_q.sid;
            rf  = RefOne;
          end
        end
        REQ_GET, REQ_FIND: begin
          rf = rec_q.refc;
          if (neg) begin
            st = ST_NOT_FOUND;
          end else if (at_max) begin
            st = ST_BAD_REF;
          end else if (sid_r == rec_q.sid) begin
            nr.refc = rec_q.refc + 1'b1;
            wr  = 1'b1;
            idv = sid_r;
            rf  = rec_q.refc + 1'b1;
          end else begin
            // stale id: a flagged slot with no references left is released
            st = ST_NOT_FOUND;
            if (rec_q.flag && is_zero) begin
              rel = 1'b1;
              rf  = '1;
            end
          end
        end
        REQ_UNREF, REQ_FREE, REQ_RX: begin
          rf = rec_q.refc;
          if (neg || sid_r != rec_q.sid) begin
            st = ST_NOT_FOUND;
          end else if (req_r == REQ_RX) begin
            nr.rx = rec_q.rx + 32'd1;
            wr    = 1'b1;
          end else if (is_zero) begin
            st = ST_BAD_REF;
          end else begin
            flg     = rec_q.flag || (req_r == REQ_FREE);
            nr.flag = flg;
            wr      = 1'b1;
            if (flg && is_one) begin
              rel = 1'b1;
              rf  = '1;
            end else begin
              nr.refc = rec_q.refc - 1'b1;
              rf      = rec_q.refc - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (state_r == B_AGE_EX && !neg) begin
      if (rec_q.rx == rec_q.lrx) begin
        t17 = {1'b0, rec_q.idle} + 17'(age_cfg.ageing_period);
        idl = t17[16] ? 16'hFFFF : t17[15:0];
        nr.idle = idl;
        nr.flag = rec_q.flag || (idl >= age_cfg.idle_limit);
      end else begin
        nr.lrx  = rec_q.rx;
        nr.idle = '0;
      end
      wr  = 1'b1;
      rel = nr.flag && is_zero;
    end
    if (rel) begin
      nr.sid  = rel_sid;
      nr.refc = '1;
      wr      = 1'b1;
    end
  end

  // memory write ports
  logic          rec_we, fifo_we, nxt_we, prv_we;
  logic [IW-1:0] rec_wa, fifo_wa, fifo_wd, nxt_wa, nxt_wd, prv_wa, prv_wd;
  rec_t          rec_wd;

  always_comb begin
    rec_we  = 1'b0;
    rec_wa  = slot_r;
    rec_wd  = nr;
    fifo_we = 1'b0;
    fifo_wa = push_addr;
    fifo_wd = slot_r;
    nxt_we  = 1'b0;
    nxt_wa  = prv_q;
    nxt_wd  = nxt_q;
    prv_we  = 1'b0;
    prv_wa  = nxt_q;
    prv_wd  = prv_q;
    if (state_r == B_CLR) begin
      rec_we      = 1'b1;
      rec_wa      = clr_cnt_r;
      rec_wd      = '0;
      rec_wd.sid  = 32'(clr_cnt_r);
      rec_wd.refc = '1;
      fifo_we     = 1'b1;
      fifo_wa     = clr_cnt_r;
      fifo_wd     = clr_cnt_r;
    end else if (commit) begin
      rec_we = wr;
      if (rel) begin
        fifo_we = (free_count_r < CW'(NUM_SLOTS));
        nxt_we  = (slot_r != used_head_r);
        prv_we  = (slot_r != used_tail_r);
      end else if (app && used_count_r != '0) begin
        nxt_we = 1'b1;
        nxt_wa = used_tail_r;
        nxt_wd = slot_r;
        prv_we = 1'b1;
        prv_wa = slot_r;
        prv_wd = used_tail_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rd_en)  rec_q <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
    if (state_r == B_AFIFO) fifo_q <= fifo_mem[free_head_r];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (rd_en)  nxt_q <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (rd_en)  prv_q <= prv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (commit && app) cph_mem[slot_r] <= cph_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLR:    if (clr_last) state_nxt = reply_r ? B_DONE : B_IDLE;
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_req) inside
            REQ_INIT:  state_nxt = B_CLR;
            REQ_ALLOC: state_nxt = (free_count_r == '0) ? B_EXEC : B_AFIFO;
            REQ_AGE:   state_nxt = B_AGE_RD;
            default:   state_nxt = B_RD;
          endcase
        end
      end
      B_AFIFO:  state_nxt = B_ARD;
      B_ARD:    state_nxt = B_EXEC;
      B_RD:     state_nxt = B_EXEC;
      B_EXEC:   if (out_free) state_nxt = B_IDLE;
      B_AGE_RD: state_nxt = (remain_r == '0) ? B_DONE : B_AGE_EX;
      B_AGE_EX: state_nxt = B_AGE_RD;
      B_DONE:   if (out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  result_t             res_nxt;
  logic [REF_BITS-1:0] refs_nxt;

  always_comb begin
    res_nxt.status         = st;
    res_nxt.id             = idv;
    res_nxt.released       = rel;
    res_nxt.released_count = '0;
    refs_nxt               = rf;
    if (state_r == B_DONE) begin
      res_nxt.status         = ST_OK;
      res_nxt.id             = '0;
      res_nxt.released       = 1'b0;
      res_nxt.released_count = (req_r == REQ_AGE) ? relcnt_r : 9'd0;
      refs_nxt               = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_CLR;
      clr_cnt_r    <= '0;
      reply_r      <= 1'b0;
      active_n_r   <= CW'(RstN);
      free_head_r  <= '0;
      free_count_r <= CW'(RstN);
      used_head_r  <= '0;
      used_tail_r  <= '0;
      used_count_r <= '0;
      remain_r     <= '0;
      relcnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_CLR: begin
          if (clr_last) begin
            clr_cnt_r    <= '0;
            free_head_r  <= '0;
            free_count_r <= active_n_r;
            used_head_r  <= '0;
            used_tail_r  <= '0;
            used_count_r <= '0;
          end else begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        B_IDLE: begin
          if (!q_empty && q_req == REQ_INIT) begin
            active_n_r <= eff_n;
            reply_r    <= 1'b1;
          end
          if (!q_empty && q_req == REQ_AGE) begin
            remain_r <= used_count_r;
            relcnt_r <= '0;
          end
        end
        B_AGE_EX: begin
          remain_r <= remain_r - 1'b1;
          if (rel) relcnt_r <= relcnt_r + 9'd1;
        end
        B_DONE:  if (out_free) reply_r <= 1'b0;
        default: ;
      endcase
      if (commit && app) begin
        if (used_count_r == '0) used_head_r <= slot_r;
        used_tail_r  <= slot_r;
        used_count_r <= used_count_r + 1'b1;
        free_head_r  <= fh_inc;
        free_count_r <= free_count_r - 1'b1;
      end
      if (commit && rel) begin
        if (slot_r == used_head_r) used_head_r <= nxt_q;
        if (slot_r == used_tail_r) used_tail_r <= prv_q;
        if (used_count_r != '0) used_count_r <= used_count_r - 1'b1;
        if (free_count_r < CW'(NUM_SLOTS)) free_count_r <= free_count_r + 1'b1;
      end
    end
  end

  // item payload and slot pointer
  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r  <= q_req;
      sid_r  <= q_sid;
      cph_r  <= q_cph;
      slot_r <= (q_req == REQ_AGE) ? used_head_r : q_idx;
    end else if (state_r == B_ARD) begin
      slot_r <= fifo_q;
    end else if (state_r == B_AGE_EX) begin
      slot_r <= nxt_q;
    end
    if (emit) begin
      res_r  <= res_nxt;
      refs_r <= refs_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_refs  = refs_r;

endmodule
`default_nettype wire

/* rtl/session_handle_table_core.sv */
// top level of the session handle table: config registers and block wiring
// flow: get, find, unref, free and rx seen pass from accept through the 4-bit-per-cycle
//   remainder unit, the queue, a record read and execute; alloc skips the remainder unit
//   and reads the free fifo first; init runs a clearing pass; age tick visits each used slot
// intake: one word in flight in the intake, so the next word is taken only once the last
//   has been pushed to the queue; the table engine reads, modifies and writes a record
// reset: synchronous, active low; afterwards a clearing pass fills the slot records and
//   free fifo, and in_ready stays low until it is done
`timescale 1ns / 1ps
`default_nettype none
module session_handle_table_core #(
  parameter int NUM_SLOTS = 256,
  parameter int REF_BITS  = 17
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // request words
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire [2:0]                  in_req_type,
  input  wire [31:0]                 in_session_id,
  input  wire [31:0]                 in_client_address,
  input  wire [7:0]                  in_cipher_kind,
  // result words
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_id_out,
  output logic signed [REF_BITS-1:0] out_refs_out,
  output logic                       out_released,
  output logic [8:0]                 out_released_count,
  // configuration writes
  input  wire                        cfg_we,
  input  wire [1:0]                  cfg_index,
  input  wire [31:0]                 cfg_wdata
);
  import shd_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int QW = 3 + 32 + 8 + IW;

  // configuration registers
  logic [8:0]  num_sessions_r;
  logic [31:0] srv_base_r;
  logic [7:0]  ageing_period_r;
  logic [15:0] idle_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sessions_r  <= RST_NUM_SESSIONS;
      srv_base_r      <= RST_SRV_BASE;
      ageing_period_r <= RST_AGEING_PERIOD;
      idle_limit_r    <= RST_IDLE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_SESSIONS:  num_sessions_r  <= cfg_wdata[8:0];
        CFG_SRV_BASE:      srv_base_r      <= cfg_wdata;
        CFG_AGEING_PERIOD: ageing_period_r <= cfg_wdata[7:0];
        CFG_IDLE_LIMIT:    idle_limit_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // slot count that init installs: zero acts as one, capped at the table depth
  logic [CW-1:0] eff_n;
  always_comb begin
    if (num_sessions_r == '0)                    eff_n = CW'(1);
    else if (32'(num_sessions_r) > NUM_SLOTS)    eff_n = CW'(NUM_SLOTS);
    else                                         eff_n = CW'(num_sessions_r);
  end

  age_cfg_t age_cfg;
  assign age_cfg.ageing_period = ageing_period_r;
  assign age_cfg.idle_limit    = idle_limit_r;

  logic          clearing, push, q_full, q_empty, q_pop;
  logic [QW-1:0] push_data, q_data;
  result_t       res;
  logic [REF_BITS-1:0] refs;

  // intake: derives the id and the slot index
  shd_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_session_id     (in_session_id),
    .in_client_address (in_client_address),
    .in_cipher_kind    (in_cipher_kind),
    .srv_base          (srv_base_r),
    .eff_n             (eff_n),
    .clearing          (clearing),
    .q_full            (q_full),
    .push              (push),
    .push_data         (push_data)
  );

  // decouples intake from the table engine
  shd_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .head_data (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // table engine with the result register
  shd_back #(.NUM_SLOTS(NUM_SLOTS), .REF_BITS(REF_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .eff_n     (eff_n),
    .age_cfg   (age_cfg),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_refs  (refs)
  );

  assign out_status         = res.status;
  assign out_id_out         = res.id;
  assign out_refs_out       = refs;
  assign out_released       = res.released;
  assign out_released_count = res.released_count;

endmodule
`default_nettype wire
